### sv/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// shared types, widths and constants of the sensor pot trim loop
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int SMP_W   = 12;
    localparam int MV_W    = 12;
    localparam int POT_W   = 10;
    localparam int GAIN_W  = 16;
    localparam int OPND_W  = 17;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int REG_IDX_W = 3;
    localparam int INIT_W  = 15;
    localparam int SHRT_W  = 14;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WIN_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_HIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BAND_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BAND_LOW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POT_START = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAIN      = 3'd5;

    // command and status codes
    localparam logic CMD_INIT   = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // reset values
    localparam logic [MV_W-1:0]   WIN_LOW_RST   = 12'd1800;
    localparam logic [MV_W-1:0]   WIN_HIGH_RST  = 12'd2200;
    localparam logic [MV_W-1:0]   BAND_HIGH_RST = 12'd2005;
    localparam logic [MV_W-1:0]   BAND_LOW_RST  = 12'd1995;
    localparam logic [POT_W-1:0]  POT_START_RST = 10'd716;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd52665;

    localparam logic [POT_W-1:0]  POT_MAX = 10'd1023;

    // multiplier constants
    localparam logic [OPND_W-1:0] MUL_INIT  = 17'd5;
    localparam logic [OPND_W-1:0] MUL_AVG   = 17'd19;
    localparam logic [OPND_W-1:0] MUL_SHORT = 17'd2;
    // ceil(2^21 / 20), exact for dividends below 2^18
    localparam logic [OPND_W-1:0] RECIP_20  = 17'd104858;
    // ceil(2^16 / 3), exact for dividends below 2^15
    localparam logic [OPND_W-1:0] RECIP_3   = 17'd21846;

    typedef struct packed {
        logic [MV_W-1:0]   win_low;
        logic [MV_W-1:0]   win_high;
        logic [MV_W-1:0]   band_high;
        logic [MV_W-1:0]   band_low;
        logic [POT_W-1:0]  pot_start;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    typedef struct packed {
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        logic [OPND_W-1:0] c;
    } t_mac_op;

endpackage

### sv/stl_mac.sv
// ----------------------------------------------------------------------------
// stl_mac
// shared multiply-add unit with registered result: acc = a * b + c
// ----------------------------------------------------------------------------
module stl_mac (
    input  logic                   i_clk,
    input  stl_pkg::t_mac_op       i_op,
    output logic [stl_pkg::ACC_W-1:0] o_acc
);

    logic [stl_pkg::PROD_W-1:0] prod;
    logic [stl_pkg::ACC_W-1:0]  r_acc;

    assign prod = i_op.a * i_op.b;

    always_ff @(posedge i_clk) begin
        r_acc <= {1'b0, prod} + {{(stl_pkg::ACC_W - stl_pkg::OPND_W){1'b0}}, i_op.c};
    end

    assign o_acc = r_acc;

endmodule

### sv/stl_cfg.sv
// ----------------------------------------------------------------------------
// stl_cfg
// apb register file for window, band, pot preset and gain
// ----------------------------------------------------------------------------
module stl_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stl_pkg::ADDR_W-1:0]  paddr,
    input  logic [stl_pkg::DATA_W-1:0]  pwdata,
    output logic [stl_pkg::DATA_W-1:0]  prdata,
    output stl_pkg::t_cfg               o_cfg,
    output logic                        o_pot_load
);

    stl_pkg::t_cfg r_cfg;
    logic          r_pot_load;
    logic          wr_en;
    logic [stl_pkg::REG_IDX_W-1:0] idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[stl_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_low   <= stl_pkg::WIN_LOW_RST;
            r_cfg.win_high  <= stl_pkg::WIN_HIGH_RST;
            r_cfg.band_high <= stl_pkg::BAND_HIGH_RST;
            r_cfg.band_low  <= stl_pkg::BAND_LOW_RST;
            r_cfg.pot_start <= stl_pkg::POT_START_RST;
            r_cfg.gain      <= stl_pkg::GAIN_RST;
            r_pot_load      <= 1'b0;
        end else begin
            r_pot_load <= 1'b0;
            if (wr_en) begin
                case (idx)
                    stl_pkg::REG_WIN_LOW:   r_cfg.win_low   <= pwdata[stl_pkg::MV_W-1:0];
                    stl_pkg::REG_WIN_HIGH:  r_cfg.win_high  <= pwdata[stl_pkg::MV_W-1:0];
                    stl_pkg::REG_BAND_HIGH: r_cfg.band_high <= pwdata[stl_pkg::MV_W-1:0];
                    stl_pkg::REG_BAND_LOW:  r_cfg.band_low  <= pwdata[stl_pkg::MV_W-1:0];
                    stl_pkg::REG_POT_START: begin
                        r_cfg.pot_start <= pwdata[stl_pkg::POT_W-1:0];
                        r_pot_load      <= 1'b1;
                    end
                    stl_pkg::REG_GAIN:      r_cfg.gain      <= pwdata[stl_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            stl_pkg::REG_WIN_LOW:   prdata[stl_pkg::MV_W-1:0]   = r_cfg.win_low;
            stl_pkg::REG_WIN_HIGH:  prdata[stl_pkg::MV_W-1:0]   = r_cfg.win_high;
            stl_pkg::REG_BAND_HIGH: prdata[stl_pkg::MV_W-1:0]   = r_cfg.band_high;
            stl_pkg::REG_BAND_LOW:  prdata[stl_pkg::MV_W-1:0]   = r_cfg.band_low;
            stl_pkg::REG_POT_START: prdata[stl_pkg::POT_W-1:0]  = r_cfg.pot_start;
            stl_pkg::REG_GAIN:      prdata[stl_pkg::GAIN_W-1:0] = r_cfg.gain;
            default:                prdata = '0;
        endcase
    end

    assign o_cfg      = r_cfg;
    assign o_pot_load = r_pot_load;

endmodule

### sv/sensor_pot_trim_loop.sv
// ----------------------------------------------------------------------------
// sensor_pot_trim_loop
// trims a digital pot so that a sensor output holds near 2000 mv
// ----------------------------------------------------------------------------
// each input transaction is an init check (command 0) or a one-second tick
// (command 1) with a raw 12-bit adc sample, and each gives exactly one result
// transaction. a tick converts the sample to millivolts with the q16 gain;
// the first tick seeds the running average and makes the loop active, later
// ticks fold the reading in at 19/20, form the short average (2*avg + mv)/3
// and step the pot down or up by one outside the dead band, saturating at 0
// and 1023. an init check while idle tests five times the sample against the
// window. all arithmetic runs through one multiply-add unit with a
// registered result; an init check, a first tick or an out-of-window tick
// is answered from the check state, while a full tick update goes on to
// scale by 19 and add mv, divide by 20 through a reciprocal, form the short
// sum, divide by 3 and make the band decision. o_ready is high only while
// the sequencer is idle and the output register is empty or being emptied
// in the same cycle, so a result that waits stalls the input and no working
// value is ever left sitting in the multiply-add unit. writing pot_start
// raises a registered load strobe, which then reloads the pot setting.
// there is no clearing pass.
// ----------------------------------------------------------------------------
module sensor_pot_trim_loop (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_command,
    input  logic [stl_pkg::SMP_W-1:0]   i_sample,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_status,
    output logic                        o_pot_write,
    output logic [stl_pkg::POT_W-1:0]   o_pot_value,
    output logic [stl_pkg::MV_W-1:0]    o_filtered_mv,
    output logic                        o_loop_active,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stl_pkg::ADDR_W-1:0]  paddr,
    input  logic [stl_pkg::DATA_W-1:0]  pwdata,
    output logic [stl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // one-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,  // wait for a transaction, issue the first multiply
        S_CHK  = 6'b000010,  // mv or 5*sample ready, decide the short cases
        S_D20  = 6'b000100,  // divide 19*avg + mv by 20
        S_SUM  = 6'b001000,  // commit new average, form 2*avg + mv
        S_D3   = 6'b010000,  // divide by 3
        S_UPD  = 6'b100000   // band test and pot step
    } t_state;

    t_state r_state, n_state;

    stl_pkg::t_cfg    cfg;
    logic             pot_load;
    stl_pkg::t_mac_op mac_op;
    logic [stl_pkg::ACC_W-1:0] acc;

    // loop state
    logic                        r_active, n_active;
    logic [stl_pkg::MV_W-1:0]    r_avg, n_avg;
    logic [stl_pkg::POT_W-1:0]   r_pot, n_pot;
    // per-item working registers
    logic                        r_cmd, n_cmd;
    logic [stl_pkg::MV_W-1:0]    r_mv, n_mv;
    // output register
    logic                        r_out_valid, n_out_valid;
    logic                        r_status, n_status;
    logic                        r_wr, n_wr;
    logic [stl_pkg::POT_W-1:0]   r_o_pot, n_o_pot;
    logic [stl_pkg::MV_W-1:0]    r_o_avg, n_o_avg;
    logic                        r_o_active, n_o_active;

    // views of the accumulator
    logic [stl_pkg::MV_W-1:0]    acc_mv;
    logic [stl_pkg::INIT_W-1:0]  acc_init;
    logic [stl_pkg::MV_W-1:0]    acc_q20;
    logic [stl_pkg::SHRT_W-1:0]  acc_q3;
    logic                        out_free;

    assign acc_mv   = acc[27:16];
    assign acc_init = acc[stl_pkg::INIT_W-1:0];
    assign acc_q20  = acc[32:21];
    assign acc_q3   = acc[29:16];
    assign out_free = !r_out_valid || i_ready;

    stl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .o_cfg      (cfg),
        .o_pot_load (pot_load)
    );

    stl_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .o_acc (acc)
    );

    assign pready  = 1'b1;
    // take a transaction only when its result has a free slot to land in
    assign o_ready = (r_state == S_IDLE) && out_free;

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_avg       = r_avg;
        n_pot       = r_pot;
        n_cmd       = r_cmd;
        n_mv        = r_mv;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_wr        = r_wr;
        n_o_pot     = r_o_pot;
        n_o_avg     = r_o_avg;
        n_o_active  = r_o_active;
        mac_op      = '0;

        case (r_state)
            S_IDLE: begin
                // tick: gain * sample, init check: 5 * sample
                mac_op.a = {{(stl_pkg::OPND_W - stl_pkg::SMP_W){1'b0}}, i_sample};
                mac_op.b = (i_command == stl_pkg::CMD_TICK) ? {1'b0, cfg.gain}
                                                            : stl_pkg::MUL_INIT;
                if (i_valid && out_free) begin
                    n_cmd   = i_command;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (out_free) begin
                    n_mv     = acc_mv;
                    // start 19*avg + mv in case this is a full update
                    mac_op.a = {5'b0, r_avg};
                    mac_op.b = stl_pkg::MUL_AVG;
                    mac_op.c = {5'b0, acc_mv};
                    if (r_cmd == stl_pkg::CMD_INIT) begin
                        // init check, ignored once the loop is active
                        n_wr     = !r_active;
                        n_status = (!r_active &&
                                    !(acc_init > {3'b0, cfg.win_low} &&
                                      acc_init < {3'b0, cfg.win_high}))
                                   ? stl_pkg::STATUS_ERR : stl_pkg::STATUS_OK;
                        n_state  = S_IDLE;
                        n_out_valid = 1'b1;
                    end else if (!r_active) begin
                        // first tick seeds the average
                        n_avg    = acc_mv;
                        n_active = 1'b1;
                        n_status = stl_pkg::STATUS_OK;
                        n_wr     = !(acc_mv > cfg.win_low && acc_mv < cfg.win_high);
                        n_state  = S_IDLE;
                        n_out_valid = 1'b1;
                    end else if (!(r_avg > cfg.win_low && r_avg < cfg.win_high)) begin
                        // average left the window: report, keep state
                        n_status = stl_pkg::STATUS_ERR;
                        n_wr     = 1'b0;
                        n_state  = S_IDLE;
                        n_out_valid = 1'b1;
                    end else begin
                        n_state  = S_D20;
                    end
                    n_o_pot    = r_pot;
                    n_o_avg    = n_avg;
                    n_o_active = n_active;
                end
            end
            S_D20: begin
                mac_op.a = acc[stl_pkg::OPND_W-1:0];
                mac_op.b = stl_pkg::RECIP_20;
                n_state  = S_SUM;
            end
            S_SUM: begin
                n_avg    = acc_q20;
                mac_op.a = {5'b0, acc_q20};
                mac_op.b = stl_pkg::MUL_SHORT;
                mac_op.c = {5'b0, r_mv};
                n_state  = S_D3;
            end
            S_D3: begin
                mac_op.a = acc[stl_pkg::OPND_W-1:0];
                mac_op.b = stl_pkg::RECIP_3;
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_status = stl_pkg::STATUS_OK;
                    // high side of the band is checked first
                    if (acc_q3 > {2'b0, cfg.band_high}) begin
                        n_wr = 1'b1;
                        if (r_pot != '0) begin
                            n_pot = r_pot - 10'd1;
                        end
                    end else if (acc_q3 < {2'b0, cfg.band_low}) begin
                        n_wr = 1'b1;
                        if (r_pot != stl_pkg::POT_MAX) begin
                            n_pot = r_pot + 10'd1;
                        end
                    end else begin
                        n_wr = 1'b0;
                    end
                    n_o_pot     = n_pot;
                    n_o_avg     = r_avg;
                    n_o_active  = r_active;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // pot preset written over apb; the user is bound to write it only while idle, the block has no guard
        if (pot_load) begin
            n_pot = cfg.pot_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_avg       <= '0;
            r_pot       <= stl_pkg::POT_START_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_avg       <= n_avg;
            r_pot       <= n_pot;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_mv       <= n_mv;
        r_status   <= n_status;
        r_wr       <= n_wr;
        r_o_pot    <= n_o_pot;
        r_o_avg    <= n_o_avg;
        r_o_active <= n_o_active;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_pot_write   = r_wr;
    assign o_pot_value   = r_o_pot;
    assign o_filtered_mv = r_o_avg;
    assign o_loop_active = r_o_active;

`ifndef SYNTH
    // the block is not ready again in the cycle after it accepts a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken on the cycle after an accepted transaction");

    // the pot moves by at most one step unless the preset is reloaded
    a_pot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(pot_load)) |->
        (r_pot == $past(r_pot)) || (r_pot == $past(r_pot) + 10'd1) ||
        (r_pot == $past(r_pot) - 10'd1))
        else $error("pot setting jumped by more than one step");

    // once active the loop stays active until reset
    a_active_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_active))
        else $error("loop dropped out of active state");

    // a full update only runs for a tick while the loop is active
    a_update_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_D20) |-> (r_active && (r_cmd == stl_pkg::CMD_TICK)))
        else $error("average update entered without an active tick");
`endif

endmodule

### tb/sensor_pot_trim_loop_tb.sv
// ----------------------------------------------------------------------------
// sensor_pot_trim_loop_tb
// self-checking testbench of the sensor pot trim loop
// ----------------------------------------------------------------------------
// a cycle-free predictor of the trim loop runs beside the block and queues
// the expected result of every accepted input transaction; a checker process
// compares each result transaction field by field with the oldest entry.
// directed tests cover the idle init checks, the seeding tick, pot
// saturation, inverted band and empty window; random tests then drive
// mostly well-formed tick streams near the running average under changing
// register settings, with random idling on both channels in all but the last run.
// ----------------------------------------------------------------------------
module sensor_pot_trim_loop_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   MV_MAX     = 4095;
    localparam int   STALL_LIMIT = 5000;

    typedef struct packed {
        logic                       status;
        logic                       pot_write;
        logic [stl_pkg::POT_W-1:0]  pot;
        logic [stl_pkg::MV_W-1:0]   filtered;
        logic                       active;
    } t_trim_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_command;
    logic [stl_pkg::SMP_W-1:0]    i_sample;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_status;
    logic                         o_pot_write;
    logic [stl_pkg::POT_W-1:0]    o_pot_value;
    logic [stl_pkg::MV_W-1:0]     o_filtered_mv;
    logic                         o_loop_active;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [stl_pkg::ADDR_W-1:0]   paddr;
    logic [stl_pkg::DATA_W-1:0]   pwdata;
    logic [stl_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    // mirror of the registers and the loop state
    stl_pkg::t_cfg                trim_cfg;
    logic                         loop_on;
    logic [stl_pkg::MV_W-1:0]     avg_mv;
    logic [stl_pkg::POT_W-1:0]    pot_set;

    t_trim_result        expected_trim[$];
    int                  failures = 0;
    int                  idle_cycles = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;

    sensor_pot_trim_loop uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_pot_write   (o_pot_write),
        .o_pot_value   (o_pot_value),
        .o_filtered_mv (o_filtered_mv),
        .o_loop_active (o_loop_active),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // strict window test, registers taken as given (empty when inverted)
    function automatic logic in_window(input logic [stl_pkg::INIT_W-1:0] mv);
        return (mv > trim_cfg.win_low) && (mv < trim_cfg.win_high);
    endfunction

    // works out the result of one accepted transaction and queues it
    function automatic void predict_trim_step(input logic cmd,
                                              input logic [stl_pkg::SMP_W-1:0] smp);
        t_trim_result                r;
        logic [27:0]                 prod;
        logic [stl_pkg::MV_W-1:0]    mv;
        logic [stl_pkg::INIT_W-1:0]  init_mv;
        int unsigned                 new_avg;
        int unsigned                 short_mv;
        r.status = stl_pkg::STATUS_OK;
        r.pot_write = 1'b0;
        if (cmd == stl_pkg::CMD_INIT) begin
            // init check only counts while idle, five times the raw sample
            if (!loop_on) begin
                init_mv = {3'b000, smp} * 15'd5;
                r.pot_write = 1'b1;
                r.status = in_window(init_mv) ? stl_pkg::STATUS_OK : stl_pkg::STATUS_ERR;
            end
        end else begin
            // q16 gain, floor rounding
            prod = trim_cfg.gain * smp;
            mv = prod[27:16];
            if (!loop_on) begin
                // first tick seeds the average, pot rewritten if out of window
                avg_mv = mv;
                loop_on = 1'b1;
                r.pot_write = !in_window({3'b000, mv});
            end else if (in_window({3'b000, avg_mv})) begin
                new_avg = (avg_mv * 19 + mv) / 20;
                avg_mv = new_avg[stl_pkg::MV_W-1:0];
                short_mv = (avg_mv * 2 + mv) / 3;
                // high side of the band wins when the band is inverted
                if (short_mv > trim_cfg.band_high) begin
                    if (pot_set != '0)
                        pot_set = pot_set - 1'b1;
                    r.pot_write = 1'b1;
                end else if (short_mv < trim_cfg.band_low) begin
                    if (pot_set != stl_pkg::POT_MAX)
                        pot_set = pot_set + 1'b1;
                    r.pot_write = 1'b1;
                end
            end else begin
                // average has drifted out of the window, loop frozen
                r.status = stl_pkg::STATUS_ERR;
            end
        end
        r.pot = pot_set;
        r.filtered = avg_mv;
        r.active = loop_on;
        expected_trim.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_trim_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_trim.size() == 0) begin
                note_failure("unexpected result transaction with nothing pending");
            end else begin
                exp_r = expected_trim.pop_front();
                if (o_status !== exp_r.status || o_pot_write !== exp_r.pot_write
                        || o_pot_value !== exp_r.pot || o_filtered_mv !== exp_r.filtered
                        || o_loop_active !== exp_r.active)
                    note_failure($sformatf({"mismatch (exp/act): status %0d/%0d ",
                        "pot_write %0d/%0d pot %0d/%0d filtered %0d/%0d active %0d/%0d"},
                        exp_r.status, o_status, exp_r.pot_write, o_pot_write,
                        exp_r.pot, o_pot_value, exp_r.filtered, o_filtered_mv,
                        exp_r.active, o_loop_active));
            end
        end
    end

    // receiver side stalls
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles without any transaction or register access
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL sensor_pot_trim_loop");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one input transaction; valid is only lowered during a gap so that it
    // never drops and rises within one step
    task automatic send_item(input logic cmd, input logic [stl_pkg::SMP_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_sample <= smp;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_trim_step(cmd, smp);
    endtask

    // holds off input until every pending result is back, then lets the
    // sequencer run out its latency
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_trim.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // apb write: setup then access, pready tied high
    task automatic write_reg(input logic [stl_pkg::REG_IDX_W-1:0] idx,
                             input logic [stl_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            stl_pkg::REG_WIN_LOW:   trim_cfg.win_low = value[stl_pkg::MV_W-1:0];
            stl_pkg::REG_WIN_HIGH:  trim_cfg.win_high = value[stl_pkg::MV_W-1:0];
            stl_pkg::REG_BAND_HIGH: trim_cfg.band_high = value[stl_pkg::MV_W-1:0];
            stl_pkg::REG_BAND_LOW:  trim_cfg.band_low = value[stl_pkg::MV_W-1:0];
            stl_pkg::REG_POT_START: begin
                trim_cfg.pot_start = value[stl_pkg::POT_W-1:0];
                pot_set = value[stl_pkg::POT_W-1:0];
            end
            stl_pkg::REG_GAIN:      trim_cfg.gain = value[stl_pkg::GAIN_W-1:0];
            default: ;
        endcase
        // pot setting reloads after the access through the registered load strobe
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [stl_pkg::MV_W-1:0] clamp_mv(input int v);
        logic [stl_pkg::MV_W-1:0] c;
        if (v < 0)
            c = '0;
        else if (v > MV_MAX)
            c = MV_MAX[stl_pkg::MV_W-1:0];
        else
            c = v[stl_pkg::MV_W-1:0];
        return c;
    endfunction

    // raw sample that lands near a millivolt target at the current gain
    function automatic logic [stl_pkg::SMP_W-1:0] sample_for_mv(input int mv);
        int unsigned s;
        logic [stl_pkg::SMP_W-1:0] smp;
        if (trim_cfg.gain == '0) begin
            s = $urandom_range(4095);
            smp = s[stl_pkg::SMP_W-1:0];
        end else begin
            s = (mv * 65536) / trim_cfg.gain;
            if (s > 4095)
                s = 4095;
            smp = s[stl_pkg::SMP_W-1:0];
        end
        return smp;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // init checks while idle against the default 1800..2200 window,
    // including both edges of the window, which are outside
    task automatic test_idle_init_checks();
        send_item(stl_pkg::CMD_INIT, 12'd0);
        send_item(stl_pkg::CMD_INIT, 12'd4095);
        send_item(stl_pkg::CMD_INIT, 12'd360);
        send_item(stl_pkg::CMD_INIT, 12'd361);
        send_item(stl_pkg::CMD_INIT, 12'd439);
        send_item(stl_pkg::CMD_INIT, 12'd440);
        send_item(stl_pkg::CMD_INIT, 12'h555);
        send_item(stl_pkg::CMD_INIT, 12'hAAA);
    endtask

    // seeding tick out of the window rewrites the pot, the following tick
    // sees a frozen loop, init checks are ignored once active
    task automatic test_first_tick_seed();
        send_item(stl_pkg::CMD_TICK, 12'd4095);
        send_item(stl_pkg::CMD_TICK, 12'd2489);
        send_item(stl_pkg::CMD_INIT, 12'd4095);
        send_item(stl_pkg::CMD_INIT, 12'd0);
    endtask

    // pot pinned at both ends while steps keep asking past them
    task automatic test_pot_saturation();
        settle_block();
        write_reg(stl_pkg::REG_WIN_LOW, 32'd0);
        write_reg(stl_pkg::REG_WIN_HIGH, 32'd4095);
        write_reg(stl_pkg::REG_POT_START, 32'd0);
        send_item(stl_pkg::CMD_TICK, 12'd4095);
        send_item(stl_pkg::CMD_TICK, 12'd4095);
        settle_block();
        write_reg(stl_pkg::REG_POT_START, 32'd1023);
        write_reg(stl_pkg::REG_BAND_HIGH, 32'd4095);
        write_reg(stl_pkg::REG_BAND_LOW, 32'd4095);
        send_item(stl_pkg::CMD_TICK, 12'd0);
        send_item(stl_pkg::CMD_TICK, 12'd0);
    endtask

    // inverted band, band covering everything, empty window, gain extremes
    task automatic test_band_and_window_corners();
        settle_block();
        write_reg(stl_pkg::REG_BAND_HIGH, 32'd0);
        write_reg(stl_pkg::REG_BAND_LOW, 32'd4095);
        send_item(stl_pkg::CMD_TICK, 12'd2489);
        settle_block();
        write_reg(stl_pkg::REG_BAND_HIGH, 32'd4095);
        write_reg(stl_pkg::REG_BAND_LOW, 32'd0);
        send_item(stl_pkg::CMD_TICK, 12'd2489);
        settle_block();
        write_reg(stl_pkg::REG_WIN_LOW, 32'd4095);
        write_reg(stl_pkg::REG_WIN_HIGH, 32'd0);
        send_item(stl_pkg::CMD_TICK, 12'd2489);
        settle_block();
        write_reg(stl_pkg::REG_WIN_LOW, 32'd0);
        write_reg(stl_pkg::REG_WIN_HIGH, 32'd4095);
        write_reg(stl_pkg::REG_GAIN, 32'd65535);
        send_item(stl_pkg::CMD_TICK, 12'd4095);
        settle_block();
        write_reg(stl_pkg::REG_GAIN, 32'd0);
        send_item(stl_pkg::CMD_TICK, 12'd4095);
    endtask

    // new register setting between chunks; the window is mostly placed
    // around the current average so the loop keeps tracking
    task automatic randomize_trim_config();
        int unsigned mode;
        int          c;
        logic [stl_pkg::MV_W-1:0] lo;
        logic [stl_pkg::MV_W-1:0] hi;
        mode = $urandom_range(9);
        c = avg_mv;
        if (mode == 0) begin
            write_reg(stl_pkg::REG_WIN_LOW, $urandom_range(1) ? 32'd4095 : 32'd0);
            write_reg(stl_pkg::REG_WIN_HIGH, $urandom_range(1) ? 32'd4095 : 32'd0);
            write_reg(stl_pkg::REG_BAND_HIGH, $urandom_range(1) ? 32'd4095 : 32'd0);
            write_reg(stl_pkg::REG_BAND_LOW, $urandom_range(1) ? 32'd4095 : 32'd0);
            write_reg(stl_pkg::REG_POT_START, $urandom_range(1) ? 32'd1023 : 32'd0);
            write_reg(stl_pkg::REG_GAIN, $urandom_range(1) ? 32'd65535 : 32'd0);
        end else begin
            if (mode < 4)
                write_reg(stl_pkg::REG_GAIN, $urandom_range(65535));
            else
                write_reg(stl_pkg::REG_GAIN, $urandom_range(65535, 45000));
            lo = clamp_mv(c - int'($urandom_range(300, 1)));
            hi = clamp_mv(c + int'($urandom_range(300, 1)));
            // occasionally an inverted window, which freezes the loop
            write_reg(stl_pkg::REG_WIN_LOW, 32'((mode == 9) ? hi : lo));
            write_reg(stl_pkg::REG_WIN_HIGH, 32'((mode == 9) ? lo : hi));
            lo = clamp_mv(c - int'($urandom_range(40)));
            hi = clamp_mv(c + int'($urandom_range(40)));
            write_reg(stl_pkg::REG_BAND_HIGH, 32'((mode == 8) ? lo : hi));
            write_reg(stl_pkg::REG_BAND_LOW, 32'((mode == 8) ? hi : lo));
            if (mode < 5)
                write_reg(stl_pkg::REG_POT_START, $urandom_range(1023));
        end
    endtask

    // tick streams near the average, with some full-range samples and a
    // few init checks as noise; the block drains before every reconfig
    task automatic test_random_trim(input int tick_target, input int unsigned send_pct,
                                    input int unsigned recv_pct);
        int          ticks;
        int          chunk_len;
        int unsigned pick;
        int unsigned raw;
        logic [stl_pkg::SMP_W-1:0] smp;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        ticks = 0;
        while (ticks < tick_target) begin
            settle_block();
            randomize_trim_config();
            chunk_len = $urandom_range(60, 15);
            repeat (chunk_len) begin
                pick = $urandom_range(99);
                raw = $urandom_range(4095);
                if (pick < 8) begin
                    send_item(stl_pkg::CMD_INIT, raw[stl_pkg::SMP_W-1:0]);
                end else begin
                    if (pick < 14)
                        smp = raw[stl_pkg::SMP_W-1:0];
                    else
                        smp = sample_for_mv(int'(avg_mv) + int'($urandom_range(240)) - 120);
                    send_item(stl_pkg::CMD_TICK, smp);
                    ticks++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = stl_pkg::CMD_INIT;
        i_sample = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        trim_cfg.win_low = stl_pkg::WIN_LOW_RST;
        trim_cfg.win_high = stl_pkg::WIN_HIGH_RST;
        trim_cfg.band_high = stl_pkg::BAND_HIGH_RST;
        trim_cfg.band_low = stl_pkg::BAND_LOW_RST;
        trim_cfg.pot_start = stl_pkg::POT_START_RST;
        trim_cfg.gain = stl_pkg::GAIN_RST;
        loop_on = 1'b0;
        avg_mv = '0;
        pot_set = stl_pkg::POT_START_RST;
        send_idle_pct = 23;
        recv_stall_pct = 49;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_init_checks();
        test_first_tick_seed();
        test_pot_saturation();
        test_band_and_window_corners();

        // sender idles lightly, receiver heavily; then swapped; then none
        test_random_trim(220, 23, 49);
        test_random_trim(215, 49, 23);
        test_random_trim(215, 0, 0);

        settle_block();
        if (failures == 0)
            $display("PASS sensor_pot_trim_loop");
        else
            $display("FAIL sensor_pot_trim_loop");
        $finish;
    end

endmodule
